@@ hdl/kts_pkg.sv @@
// kts_pkg: shared types, constants and the key character map
// for the keypad to keyed serial transmitter; no dependencies
package kts_pkg;

    localparam int unsigned KeyCount   = 16;
    localparam int unsigned RowCount   = 4;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned LoadWidth  = 7;
    localparam int unsigned PosWidth   = 4;
    localparam logic [PosWidth-1:0] StopPos   = 4'd9;
    localparam logic [PosWidth-1:0] FrameBits = 4'd10;

    // operation codes carried on tuser
    localparam logic OpSample = 1'b0;
    localparam logic OpTick   = 1'b1;

    typedef struct packed {
        logic                  started;
        logic [CharWidth-1:0]  char_code;
        logic [KeyCount-1:0]   levels_next;
    } scan_res_t;

    typedef struct packed {
        logic                  carrier;
        logic [PosWidth-1:0]   pos;
        logic                  active;
        logic                  done;
    } tx_res_t;

    // hex character per key, index column*4+row
    function automatic logic [CharWidth-1:0] key_char(input logic [3:0] idx);
        logic [CharWidth-1:0] c;
        case (idx)
            4'd0:    c = 8'h46; // F
            4'd1:    c = 8'h42; // B
            4'd2:    c = 8'h37; // 7
            4'd3:    c = 8'h33; // 3
            4'd4:    c = 8'h45; // E
            4'd5:    c = 8'h41; // A
            4'd6:    c = 8'h36; // 6
            4'd7:    c = 8'h32; // 2
            4'd8:    c = 8'h44; // D
            4'd9:    c = 8'h39; // 9
            4'd10:   c = 8'h35; // 5
            4'd11:   c = 8'h31; // 1
            4'd12:   c = 8'h43; // C
            4'd13:   c = 8'h38; // 8
            4'd14:   c = 8'h34; // 4
            default: c = 8'h30; // 0
        endcase
        return c;
    endfunction

endpackage

@@ hdl/kts_scan.sv @@
// kts_scan: falling edge detect on one keypad column and key map lookup
// depends on kts_pkg
module kts_scan (
    input  logic [1:0]                       column,
    input  logic [kts_pkg::RowCount-1:0]     row_levels,
    input  logic [kts_pkg::KeyCount-1:0]     prev_levels,
    input  logic [kts_pkg::CharWidth-1:0]    char_in,
    output kts_pkg::scan_res_t               res
);

    always_comb begin
        logic [3:0] idx;
        res.started     = 1'b0;
        res.char_code   = char_in;
        res.levels_next = prev_levels;
        for (int j = 0; j < kts_pkg::RowCount; j++) begin
            idx = {column, 2'(j)};
            // highest row with a falling edge wins
            if (!row_levels[j] && prev_levels[idx]) begin
                res.started   = 1'b1;
                res.char_code = kts_pkg::key_char(idx);
            end
            res.levels_next[idx] = row_levels[j];
        end
    end

endmodule

@@ hdl/kts_tx.sv @@
// kts_tx: one bit period of the on/off keyed frame sequencer
// depends on kts_pkg
module kts_tx (
    input  logic [kts_pkg::CharWidth-1:0]  frame_char,
    input  logic [kts_pkg::PosWidth-1:0]   pos,
    input  logic                           carrier,
    input  logic                           active,
    output kts_pkg::tx_res_t               res
);

    logic [kts_pkg::PosWidth-1:0] pos_inc;
    logic [kts_pkg::PosWidth-1:0] pos_dec;

    assign pos_inc = pos + 1'b1;
    assign pos_dec = pos - 1'b1;

    always_comb begin
        res.carrier = carrier;
        res.pos     = pos;
        res.active  = active;
        res.done    = 1'b0;
        if (active) begin
            if (pos == '0) begin
                res.carrier = 1'b1;                        // start bit
            end else if (pos >= kts_pkg::StopPos) begin
                res.carrier = 1'b0;                        // stop bit
            end else begin
                res.carrier = ~frame_char[pos_dec[2:0]];   // data, lsb first
            end
            res.pos = pos_inc;
            if (pos_inc >= kts_pkg::FrameBits) begin
                res.carrier = 1'b0;
                res.pos     = '0;
                res.active  = 1'b0;
                res.done    = 1'b1;
            end
        end
    end

endmodule

@@ hdl/keypad_to_keyed_serial_tx_unit.sv @@
// keypad_to_keyed_serial_tx_unit: keypad scan feeding an on/off keyed serial frame
// the result of an accepted request is registered and shown on the master side in the next cycle
// throughput 1 request per cycle while the master side does not stall, set by the single state update per request
// synchronous active-low reset clears key levels, frame state and output valid
// depends on kts_pkg, kts_scan, kts_tx
module keypad_to_keyed_serial_tx_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] column, [5:2] row_levels, [7:6] zero
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] carrier_on, [1] sending, [2] frame_done,
                                   // [3] started, [10:4] loaded_char, [15:11] zero
);

    // key levels and frame state
    logic [kts_pkg::KeyCount-1:0]  levels_reg;
    logic [kts_pkg::CharWidth-1:0] char_reg, char_next;
    logic [kts_pkg::PosWidth-1:0]  pos_reg, pos_next;
    logic                          active_reg, active_next;
    logic                          carrier_reg, carrier_next;
    logic [kts_pkg::KeyCount-1:0]  levels_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;

    logic                accept;
    kts_pkg::scan_res_t  scan_res;
    kts_pkg::tx_res_t    tx_res;
    logic                done;
    logic                started;

    // a new request enters whenever the result slot is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    kts_scan u_scan (
        .column      (s_tdata[1:0]),
        .row_levels  (s_tdata[5:2]),
        .prev_levels (levels_reg),
        .char_in     (char_reg),
        .res         (scan_res)
    );

    kts_tx u_tx (
        .frame_char (char_reg),
        .pos        (pos_reg),
        .carrier    (carrier_reg),
        .active     (active_reg),
        .res        (tx_res)
    );

    always_comb begin
        levels_next  = levels_reg;
        char_next    = char_reg;
        pos_next     = pos_reg;
        active_next  = active_reg;
        carrier_next = carrier_reg;
        done         = 1'b0;
        started      = 1'b0;
        if (accept) begin
            if (s_tuser == kts_pkg::OpSample) begin
                // a press mid-frame swaps the character but keeps the bit count
                levels_next = scan_res.levels_next;
                char_next   = scan_res.char_code;
                started     = scan_res.started;
                if (scan_res.started) begin
                    active_next = 1'b1;
                end
            end else begin
                // tick while idle leaves everything as it is
                pos_next     = tx_res.pos;
                active_next  = tx_res.active;
                carrier_next = tx_res.carrier;
                done         = tx_res.done;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0,
                              (started ? char_next[kts_pkg::LoadWidth-1:0]
                                       : {kts_pkg::LoadWidth{1'b0}}),
                              started, done, active_next, carrier_next};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg    <= '0;
            char_reg      <= '0;
            pos_reg       <= '0;
            active_reg    <= 1'b0;
            carrier_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            levels_reg    <= levels_next;
            char_reg      <= char_next;
            pos_reg       <= pos_next;
            active_reg    <= active_next;
            carrier_reg   <= carrier_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // bit counter never runs past the stop bit
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= kts_pkg::StopPos)
        else $error("bit position beyond stop bit");

    // idle frame always sits at the first bit
    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> pos_reg == '0)
        else $error("idle with nonzero bit position");

    // end of frame drops the carrier and the busy flag
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
        else $error("frame done while still sending");

    // a press always leaves a frame in progress with a nonzero character
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[1] && m_tdata[10:4] != '0)
        else $error("start without busy frame");
`endif

endmodule
